FILE: hw/rtl/ira_pkg.sv
package ira_pkg;

    localparam int DEF_VALUE_BITS = 64;
    localparam int DEF_MAX_BASE   = 36;

    // port layout
    localparam int VALUE_W    = 64;
    localparam int BASE_W     = 6;
    localparam int S_TDATA_W  = 72;
    localparam int CHAR_W     = 8;
    localparam int DIGIT_W    = 6;

    localparam logic [BASE_W-1:0]  MIN_BASE   = 6'd2;
    localparam logic [BASE_W-1:0]  SIGN_BASE  = 6'd10;
    localparam logic [CHAR_W-1:0]  CH_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0]  CH_A       = 8'h61;
    localparam logic [CHAR_W-1:0]  CH_MINUS   = 8'h2d;
    localparam logic [CHAR_W-1:0]  CH_NONE    = 8'h00;
    localparam logic [DIGIT_W-1:0] DIGIT_TEN  = 6'd10;
    localparam logic [DIGIT_W-1:0] DIGIT_MAX  = 6'd35;

    typedef struct packed {
        logic sign;
        logic bad;
    } ira_flags_t;

    localparam int FLAGS_W = 2;

    typedef enum logic [1:0] {
        B_IDLE,
        B_DIV,
        B_SIGN,
        B_EMIT
    } ira_state_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [DIGIT_W-1:0] dc;
        dc = (d > DIGIT_MAX) ? DIGIT_MAX : d;
        if (dc < DIGIT_TEN) begin
            return CH_ZERO + CHAR_W'(dc);
        end else begin
            return CH_A + CHAR_W'(dc - DIGIT_TEN);
        end
    endfunction

endpackage

FILE: hw/rtl/ira_front.sv
module ira_front import ira_pkg::*; #(
    parameter int VALUE_BITS = DEF_VALUE_BITS,
    parameter int MAX_BASE   = DEF_MAX_BASE,
    parameter int BYTES      = (VALUE_BITS + 7) / 8,
    parameter int IDXW       = (BYTES > 1) ? $clog2(BYTES) : 1,
    parameter int ENTRY_W    = IDXW + BYTES * 8 + BASE_W + FLAGS_W
) (
    input  logic                 func,
    input  logic [VALUE_W-1:0]   value,
    input  logic [BASE_W-1:0]    base,
    output logic [ENTRY_W-1:0]   entry
);

    localparam int VW = BYTES * 8;

    logic [VALUE_BITS-1:0] val;
    logic [VALUE_BITS-1:0] mag;
    logic [VW-1:0]         mag_p;
    logic [IDXW-1:0]       top;
    ira_flags_t            flags;
    logic                  neg;

    always_comb begin
        val   = value[VALUE_BITS-1:0];
        neg   = func & val[VALUE_BITS-1];
        mag   = neg ? (~val + VALUE_BITS'(1)) : val;
        mag_p = VW'(mag);
        // highest nonzero byte of the magnitude
        top = '0;
        for (int i = 0; i < BYTES; i++) begin
            if (mag_p[i*8 +: 8] != 8'd0) begin
                top = IDXW'(i);
            end
        end
        flags.bad  = (base < MIN_BASE) || (32'(base) > MAX_BASE);
        flags.sign = neg && (base == SIGN_BASE);
        entry = {top, mag_p, base, flags};
    end

endmodule

FILE: hw/rtl/ira_queue.sv
module ira_queue import ira_pkg::*; #(
    parameter int W = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         wr_valid,
    output logic         wr_ready,
    input  logic [W-1:0] wr_data,
    output logic         rd_valid,
    input  logic         rd_ready,
    output logic [W-1:0] rd_data
);

    logic [W-1:0] mem_reg [0:1];
    logic         wp_reg, wp_next;
    logic         rp_reg, rp_next;
    logic [1:0]   cnt_reg, cnt_next;
    logic         do_wr, do_rd;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = mem_reg[rp_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_comb begin
        wp_next  = do_wr ? ~wp_reg : wp_reg;
        rp_next  = do_rd ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + 2'(do_wr) - 2'(do_rd);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem_reg[wp_reg] <= wr_data;
        end
    end

endmodule

FILE: hw/rtl/ira_back.sv
module ira_back import ira_pkg::*; #(
    parameter int VALUE_BITS = DEF_VALUE_BITS,
    parameter int BYTES      = (VALUE_BITS + 7) / 8,
    parameter int IDXW       = (BYTES > 1) ? $clog2(BYTES) : 1,
    parameter int ENTRY_W    = IDXW + BYTES * 8 + BASE_W + FLAGS_W
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    output logic                q_ready,
    input  logic [ENTRY_W-1:0]  q_data,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [CHAR_W-1:0]   m_char,
    output logic                m_bad,
    output logic                m_last
);

    localparam int VW    = BYTES * 8;
    localparam int MAXD  = VALUE_BITS;
    localparam int CNTW  = $clog2(MAXD + 1);

    ira_state_t          state_reg, state_next;
    logic [VW-1:0]       v_reg, v_next;
    logic [BASE_W-1:0]   base_reg, base_next;
    logic                sign_reg, sign_next;
    logic [IDXW-1:0]     idx_reg, idx_next;
    logic [IDXW-1:0]     top_reg, top_next;
    logic                nz_reg, nz_next;
    logic [DIGIT_W-1:0]  rem_reg, rem_next;
    logic [CNTW-1:0]     cnt_reg, cnt_next;
    logic [DIGIT_W-1:0]  dig_reg [0:MAXD-1];

    logic                ov_reg, ov_next;
    logic [CHAR_W-1:0]   ch_reg, ch_next;
    logic                bad_reg, bad_next;
    logic                last_reg, last_next;

    ira_flags_t          e_flags;
    logic [BASE_W-1:0]   e_base;
    logic [VW-1:0]       e_mag;
    logic [IDXW-1:0]     e_top;

    logic                out_free;
    logic                push, pop;
    logic [7:0]          in_byte, qb;
    logic [6:0]          r;

    assign e_flags  = q_data[FLAGS_W-1:0];
    assign e_base   = q_data[FLAGS_W +: BASE_W];
    assign e_mag    = q_data[FLAGS_W + BASE_W +: VW];
    assign e_top    = q_data[FLAGS_W + BASE_W + VW +: IDXW];
    assign out_free = !ov_reg || m_tready;
    assign in_byte  = v_reg[idx_reg*8 +: 8];

    // one quotient byte per cycle, remainder carried between bytes
    always_comb begin
        r  = {1'b0, rem_reg};
        qb = '0;
        for (int k = 7; k >= 0; k--) begin
            r = {r[5:0], in_byte[k]};
            if (r >= {1'b0, base_reg}) begin
                r     = r - {1'b0, base_reg};
                qb[k] = 1'b1;
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        v_next     = v_reg;
        base_next  = base_reg;
        sign_next  = sign_reg;
        idx_next   = idx_reg;
        top_next   = top_reg;
        nz_next    = nz_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        ov_next    = ov_reg && !m_tready;
        ch_next    = ch_reg;
        bad_next   = bad_reg;
        last_next  = last_reg;
        q_ready    = 1'b0;
        push       = 1'b0;
        pop        = 1'b0;
        case (state_reg)
            B_IDLE: begin
                if (q_valid) begin
                    if (e_flags.bad) begin
                        if (out_free) begin
                            q_ready   = 1'b1;
                            ov_next   = 1'b1;
                            ch_next   = CH_NONE;
                            bad_next  = 1'b1;
                            last_next = 1'b1;
                        end
                    end else begin
                        q_ready    = 1'b1;
                        v_next     = e_mag;
                        base_next  = e_base;
                        sign_next  = e_flags.sign;
                        idx_next   = e_top;
                        nz_next    = 1'b0;
                        top_next   = '0;
                        rem_next   = '0;
                        cnt_next   = '0;
                        state_next = B_DIV;
                    end
                end
            end
            B_DIV: begin
                v_next[idx_reg*8 +: 8] = qb;
                rem_next = r[5:0];
                if (!nz_reg && qb != 8'd0) begin
                    nz_next  = 1'b1;
                    top_next = idx_reg;
                end
                if (idx_reg == '0) begin
                    push     = 1'b1;
                    cnt_next = cnt_reg + CNTW'(1);
                    rem_next = '0;
                    nz_next  = 1'b0;
                    top_next = '0;
                    if (nz_reg || qb != 8'd0) begin
                        idx_next = nz_reg ? top_reg : '0;
                    end else begin
                        state_next = sign_reg ? B_SIGN : B_EMIT;
                    end
                end else begin
                    idx_next = idx_reg - IDXW'(1);
                end
            end
            B_SIGN: begin
                if (out_free) begin
                    ov_next    = 1'b1;
                    ch_next    = CH_MINUS;
                    bad_next   = 1'b0;
                    last_next  = 1'b0;
                    state_next = B_EMIT;
                end
            end
            B_EMIT: begin
                if (out_free) begin
                    pop       = 1'b1;
                    ov_next   = 1'b1;
                    ch_next   = digit_char(dig_reg[0]);
                    bad_next  = 1'b0;
                    last_next = (cnt_reg == CNTW'(1));
                    cnt_next  = cnt_reg - CNTW'(1);
                    if (cnt_reg == CNTW'(1)) begin
                        state_next = B_IDLE;
                    end
                end
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
            ov_reg    <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        v_reg    <= v_next;
        base_reg <= base_next;
        sign_reg <= sign_next;
        idx_reg  <= idx_next;
        top_reg  <= top_next;
        nz_reg   <= nz_next;
        rem_reg  <= rem_next;
        ch_reg   <= ch_next;
        bad_reg  <= bad_next;
        last_reg <= last_next;
    end

    // digit stack, least significant digit pushed first
    always_ff @(posedge aclk) begin
        if (push) begin
            dig_reg[0] <= r[DIGIT_W-1:0];
            for (int i = 1; i < MAXD; i++) begin
                dig_reg[i] <= dig_reg[i-1];
            end
        end else if (pop) begin
            for (int i = 0; i < MAXD - 1; i++) begin
                dig_reg[i] <= dig_reg[i+1];
            end
        end
    end

    assign m_tvalid = ov_reg;
    assign m_char   = ch_reg;
    assign m_bad    = bad_reg;
    assign m_last   = last_reg;

    a_emit_has_digit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == B_EMIT) |-> (cnt_reg != '0))
        else $error("emit state with empty digit stack");

    a_stack_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (cnt_reg < CNTW'(MAXD)))
        else $error("digit stack overflow");

    a_rem_below_base: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == B_DIV) |-> ({1'b0, rem_reg} < {1'b0, base_reg}))
        else $error("division remainder not below base");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (ov_reg && !m_tready) |=> (ov_reg && $stable(ch_reg) && $stable(last_reg)))
        else $error("stalled result changed");

endmodule

FILE: hw/rtl/integer_to_radix_ascii.sv
// integer_to_radix_ascii: value to lower-case ascii digits in base 2..MAX_BASE, msd first
// the first character waits for the whole divide loop; a bad base skips the loop
// per item: for each digit the loop divides the significant bytes of the running quotient
//   (one byte of the shared divide step per cycle), then the characters are emitted
// reset: synchronous active-low aresetn empties the queue and clears the output valid
module integer_to_radix_ascii import ira_pkg::*; #(
    parameter int VALUE_BITS = DEF_VALUE_BITS,
    parameter int MAX_BASE   = DEF_MAX_BASE
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input transaction
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // value [63:0], base [69:64], zero [71:70]
    input  logic [0:0]            s_tuser,   // func [0]
    // result transaction
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [CHAR_W-1:0]     m_tdata,   // character [7:0]
    output logic [0:0]            m_tuser,   // bad_base [0]
    output logic                  m_tlast    // last character of the conversion
);

    localparam int BYTES   = (VALUE_BITS + 7) / 8;
    localparam int IDXW    = (BYTES > 1) ? $clog2(BYTES) : 1;
    localparam int ENTRY_W = IDXW + BYTES * 8 + BASE_W + FLAGS_W;

    logic [ENTRY_W-1:0] f_entry;
    logic [ENTRY_W-1:0] q_data;
    logic               q_valid;
    logic               q_ready;

    // front: mask, sign handling, magnitude, base check, top byte
    ira_front #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_BASE   (MAX_BASE),
        .BYTES      (BYTES),
        .IDXW       (IDXW),
        .ENTRY_W    (ENTRY_W)
    ) u_front (
        .func  (s_tuser[0]),
        .value (s_tdata[VALUE_W-1:0]),
        .base  (s_tdata[VALUE_W +: BASE_W]),
        .entry (f_entry)
    );

    // two-entry queue between classification and conversion
    ira_queue #(
        .W (ENTRY_W)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (s_tvalid),
        .wr_ready (s_tready),
        .wr_data  (f_entry),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_data)
    );

    // back: byte-wise division loop, digit stack, output register
    ira_back #(
        .VALUE_BITS (VALUE_BITS),
        .BYTES      (BYTES),
        .IDXW       (IDXW),
        .ENTRY_W    (ENTRY_W)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_data   (q_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_char   (m_tdata),
        .m_bad    (m_tuser[0]),
        .m_last   (m_tlast)
    );

endmodule

FILE: tb/tb.sv
module tb;
    import ira_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // selector codes carried in s_tuser
    localparam logic FUNC_UNSIGNED = 1'b0;
    localparam logic FUNC_SIGNED   = 1'b1;

    localparam int NUM_RANDOM   = 260;
    localparam int HOLD_CYCLES  = 3000;   // long receiver hold-off, fills the block's queue
    localparam int HOLD_AFTER   = 40;     // start the hold-off once this many conversions went in
    localparam int DRAIN_CYCLES = 400;    // covers the slowest conversion after the last character

    typedef struct {
        logic               func;
        logic [VALUE_W-1:0] value;
        logic [BASE_W-1:0]  base;
    } conv_item_t;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              bad;
        logic              last;
    } char_beat_t;

    logic                 aclk    = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [0:0]           s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [CHAR_W-1:0]    m_tdata;
    logic [0:0]           m_tuser;
    logic                 m_tlast;

    conv_item_t pending_items[$];    // conversions still to be offered
    char_beat_t expected_chars[$];   // characters the block owes us, oldest first
    conv_item_t on_wire;             // conversion currently offered on the input
    int         items_accepted = 0;
    int         error_count = 0;

    // sender burst / gap bookkeeping
    int burst_left = 0;
    int gap_left   = 0;

    // receiver stall pattern and long hold-off
    logic [31:0] ready_pattern = '1;
    int          phase_cycle   = 0;
    int          hold_left     = 0;
    logic        hold_done     = 1'b0;

    integer_to_radix_ascii dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // expected characters of one conversion, most significant digit first
    function automatic void predict_conversion(input conv_item_t it);
        logic [VALUE_W-1:0] mag;
        logic [VALUE_W-1:0] radix;
        logic [VALUE_W-1:0] rem;
        logic [CHAR_W-1:0]  lsd_first[$];
        logic               neg;
        // bad base: one flagged nul character, nothing else
        if (it.base < MIN_BASE || int'(it.base) > DEF_MAX_BASE) begin
            expected_chars.push_back('{ch: CH_NONE, bad: 1'b1, last: 1'b1});
            return;
        end
        radix = VALUE_W'(it.base);
        neg   = (it.func == FUNC_SIGNED) && it.value[VALUE_W-1];
        // magnitude in unsigned arithmetic so the most negative value still works
        mag   = neg ? (VALUE_W'(0) - it.value) : it.value;
        // zero still produces a single '0'
        do begin
            rem = mag % radix;
            if (rem < VALUE_W'(DIGIT_TEN)) begin
                lsd_first.push_back(CH_ZERO + CHAR_W'(rem));
            end else begin
                lsd_first.push_back(CH_A + CHAR_W'(rem - VALUE_W'(DIGIT_TEN)));
            end
            mag = mag / radix;
        end while (mag != '0);
        // minus sign only in decimal; other bases print the bare magnitude
        if (neg && it.base == SIGN_BASE) begin
            expected_chars.push_back('{ch: CH_MINUS, bad: 1'b0, last: 1'b0});
        end
        for (int i = lsd_first.size() - 1; i >= 0; i--) begin
            expected_chars.push_back('{ch: lsd_first[i], bad: 1'b0, last: (i == 0)});
        end
    endfunction

    task automatic add_item(input logic func, input logic [VALUE_W-1:0] value,
                            input logic [BASE_W-1:0] base);
        conv_item_t it;
        it.func  = func;
        it.value = value;
        it.base  = base;
        pending_items.push_back(it);
    endtask

    // input driver: bursts of transactions with random gaps in between
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid   <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_conversion(on_wire);
                items_accepted <= items_accepted + 1;
            end
            // the input slot is free when nothing is offered or the offer was just taken
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    on_wire  = pending_items.pop_front();
                    s_tdata  <= {2'b00, on_wire.base, on_wire.value};
                    s_tuser  <= on_wire.func;
                    s_tvalid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 12);
                        // mostly short gaps or none, now and then a long one
                        gap_left   <= ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                                 : $urandom_range(0, 3);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // long hold-off on the result side, counted on its own
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && items_accepted >= HOLD_AFTER) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // result monitor and receiver stall pattern
    always @(posedge aclk) begin
        char_beat_t want;
        char_beat_t got;
        if (!aresetn) begin
            m_tready      <= 1'b0;
            ready_pattern <= '1;
            phase_cycle   <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = '{ch: m_tdata, bad: m_tuser[0], last: m_tlast};
                if (expected_chars.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected character transaction, actual ch=%h bad=%b last=%b",
                             $time, got.ch, got.bad, got.last);
                end else begin
                    want = expected_chars.pop_front();
                    if (got.ch !== want.ch) begin
                        error_count++;
                        $display("%0t: character mismatch, expected %h actual %h",
                                 $time, want.ch, got.ch);
                    end
                    if (got.bad !== want.bad) begin
                        error_count++;
                        $display("%0t: bad_base mismatch, expected %b actual %b",
                                 $time, want.bad, got.bad);
                    end
                    if (got.last !== want.last) begin
                        error_count++;
                        $display("%0t: last mismatch, expected %b actual %b",
                                 $time, want.last, got.last);
                    end
                end
            end
            // when the phase counter wraps pick a new stall density: none, light, half or heavy
            if (phase_cycle == 255) begin
                phase_cycle <= 0;
                case ($urandom_range(0, 3))
                    0: begin
                        ready_pattern <= '1;
                    end
                    1: begin
                        ready_pattern <= $urandom | $urandom;
                    end
                    2: begin
                        ready_pattern <= $urandom;
                    end
                    default: begin
                        ready_pattern <= ($urandom & $urandom) | 32'h0000_0101;
                    end
                endcase
            end else begin
                phase_cycle   <= phase_cycle + 1;
                ready_pattern <= {ready_pattern[30:0], ready_pattern[31]};
            end
            m_tready <= (hold_left == 0) && ready_pattern[0];
        end
    end

    // stimulus and end of run
    initial begin
        conv_item_t  it;
        logic [63:0] v;
        // zero in both modes
        add_item(FUNC_UNSIGNED, 64'd0, 6'd10);
        add_item(FUNC_SIGNED,   64'd0, 6'd2);
        // all ones: longest output in base 2, then bases 36, 16 and 10
        add_item(FUNC_UNSIGNED, '1, 6'd2);
        add_item(FUNC_UNSIGNED, '1, 6'd36);
        add_item(FUNC_UNSIGNED, '1, 6'd16);
        add_item(FUNC_UNSIGNED, '1, 6'd10);
        // most negative value, decimal with sign and binary magnitude
        add_item(FUNC_SIGNED, 64'h8000_0000_0000_0000, 6'd10);
        add_item(FUNC_SIGNED, 64'h8000_0000_0000_0000, 6'd2);
        // minus one: signed decimal, signed hex without sign
        add_item(FUNC_SIGNED, '1, 6'd10);
        add_item(FUNC_SIGNED, '1, 6'd16);
        // largest positive signed value
        add_item(FUNC_SIGNED, 64'h7fff_ffff_ffff_ffff, 6'd10);
        // negative in decimal but read unsigned: no sign
        add_item(FUNC_UNSIGNED, 64'hffff_ffff_ffff_ff85, 6'd10);
        // highest single digit in decimal and in base 36, then the first two-digit value in base 36
        add_item(FUNC_UNSIGNED, 64'd9, 6'd10);
        add_item(FUNC_UNSIGNED, 64'd35, 6'd36);
        add_item(FUNC_UNSIGNED, 64'd36, 6'd36);
        // odd bases with random values
        add_item(FUNC_UNSIGNED, {$urandom, $urandom}, 6'd3);
        add_item(FUNC_SIGNED,   {$urandom, $urandom}, 6'd7);
        // bad bases: below 2, just above 36, and the top code
        add_item(FUNC_UNSIGNED, {$urandom, $urandom}, 6'd0);
        add_item(FUNC_SIGNED,   '1, 6'd1);
        add_item(FUNC_UNSIGNED, 64'd0, 6'd37);
        add_item(FUNC_SIGNED,   {$urandom, $urandom}, 6'd63);

        for (int n = 0; n < NUM_RANDOM; n++) begin
            it.func = 1'($urandom_range(0, 1));
            // mostly valid bases, some drawn from the whole field
            if ($urandom_range(0, 9) == 0) begin
                it.base = BASE_W'($urandom_range(0, 63));
            end else begin
                it.base = BASE_W'($urandom_range(2, 36));
            end
            case ($urandom_range(0, 5))
                0: v = 64'($urandom_range(0, 1000));
                1: v = 64'(0) - 64'($urandom_range(1, 1000));
                2: v = {$urandom, $urandom} >> $urandom_range(0, 63);
                3: v = ($urandom_range(0, 1) == 1)
                       ? 64'h8000_0000_0000_0000 ^ 64'($urandom_range(0, 3))
                       : 64'h7fff_ffff_ffff_ffff ^ 64'($urandom_range(0, 3));
                default: v = {$urandom, $urandom};
            endcase
            it.value = v;
            pending_items.push_back(it);
        end

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // all offered and every expected character seen
        do begin
            @(posedge aclk);
            #1;
        end while (pending_items.size() != 0 || s_tvalid || expected_chars.size() != 0);
        // quiet period to catch stray characters
        repeat (DRAIN_CYCLES) @(posedge aclk);
        #1;
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // run limit, far above the slowest legal run
    initial begin
        #40_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
